[src/mvl_pkg.sv]
package mvl_pkg;

    localparam int SINE_ENTRIES = 1024;
    localparam int SINE_DIV = SINE_ENTRIES - 1;
    localparam int TAB_ENTRIES = 256;
    localparam int TAB_STEP = SINE_ENTRIES / TAB_ENTRIES;
    localparam int QUARTER_OFS = SINE_ENTRIES / 4 / TAB_STEP;
    localparam int DEF_QUEUE_DEPTH = 4;

    localparam int COORD_W = 16;
    localparam int PACK_W = 16;
    localparam int ANG_W = 8;
    localparam int SIN_W = 16;
    localparam int WGT_W = 16;
    localparam int POS_W = 24;
    localparam int NRM_W = 16;

    localparam int WGT_ONE = 1 << WGT_W;
    localparam int WGT_SHIFT = 16;
    localparam int POS_SHIFT = 8;
    localparam int FRAC_Q14 = 14;
    localparam int ROUND_Q14 = 8192;
    localparam int NORM_ONE = 16384;

    localparam int PP_W = 34;
    localparam int C_W = 30;
    localparam int BL_W = 46;
    localparam int SQ_W = 57;
    localparam int LEN_W = 58;
    localparam int RES_W = LEN_W + 1;
    localparam int ROOT_W = 29;
    localparam int MAG_W = 29;
    localparam int QN_W = MAG_W + FRAC_Q14;
    localparam int Q_W = 15;

    localparam longint unsigned HALF_PI_Q62 = 64'd7244019458077122842;
    localparam int TAYLOR_TERMS = 14;
    localparam longint unsigned TAYLOR_DEN [1:TAYLOR_TERMS] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210,
        64'd272, 64'd342, 64'd420, 64'd506, 64'd600, 64'd702, 64'd812
    };

    typedef logic signed [SIN_W-1:0] sine_tab_t [TAB_ENTRIES];

    typedef struct packed {
        logic signed [COORD_W-1:0] new_x;
        logic signed [COORD_W-1:0] new_y;
        logic signed [COORD_W-1:0] new_z;
        logic [PACK_W-1:0]         new_packed_normal;
        logic signed [COORD_W-1:0] old_x;
        logic signed [COORD_W-1:0] old_y;
        logic signed [COORD_W-1:0] old_z;
        logic [PACK_W-1:0]         old_packed_normal;
        logic                      last_vertex_in;
    } in_item_t;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic signed [NRM_W-1:0] norm_x;
        logic signed [NRM_W-1:0] norm_y;
        logic signed [NRM_W-1:0] norm_z;
        logic                    last_vertex_out;
    } out_item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] new_x;
        logic signed [COORD_W-1:0] new_y;
        logic signed [COORD_W-1:0] new_z;
        logic signed [COORD_W-1:0] old_x;
        logic signed [COORD_W-1:0] old_y;
        logic signed [COORD_W-1:0] old_z;
        logic signed [SIN_W-1:0]   n_cos_lat;
        logic signed [SIN_W-1:0]   n_sin_lat;
        logic signed [SIN_W-1:0]   n_sin_lng;
        logic signed [SIN_W-1:0]   n_cos_lng;
        logic signed [SIN_W-1:0]   o_cos_lat;
        logic signed [SIN_W-1:0]   o_sin_lat;
        logic signed [SIN_W-1:0]   o_sin_lng;
        logic signed [SIN_W-1:0]   o_cos_lng;
        logic                      last;
    } vtx_item_t;

    function automatic longint unsigned mul_q62(input longint unsigned a,
                                                input longint unsigned b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    function automatic longint unsigned sin_quarter(input longint unsigned r);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned sum;
        x = (HALF_PI_Q62 / SINE_DIV) * r + ((HALF_PI_Q62 % SINE_DIV) * r) / SINE_DIV;
        x2 = mul_q62(x, x);
        term = x;
        sum = x;
        for (int k = 1; k <= TAYLOR_TERMS; k++) begin
            term = mul_q62(term, x2) / TAYLOR_DEN[k];
            if (k[0]) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        return sum;
    endfunction

    function automatic sine_tab_t build_sine_tab();
        sine_tab_t tab;
        longint unsigned n;
        longint unsigned quad;
        longint unsigned r;
        longint unsigned s;
        longint unsigned e;
        for (int k = 0; k < TAB_ENTRIES; k++) begin
            n = 64'(k * TAB_STEP * 4);
            quad = (n / SINE_DIV) & 64'd3;
            r = n % SINE_DIV;
            s = quad[0] ? sin_quarter(64'(SINE_DIV) - r) : sin_quarter(r);
            e = (s + (64'd1 << 47)) >> 48;
            tab[k] = quad[1] ? SIN_W'(-e) : SIN_W'(e);
        end
        return tab;
    endfunction

    localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

[src/mvl_front.sv]
module mvl_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  mvl_pkg::in_item_t    s_data,
    output logic                 push,
    output mvl_pkg::vtx_item_t   push_item,
    input  logic                 q_full
);
    import mvl_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    vtx_item_t item_reg;
    vtx_item_t item_next;
    logic      accept;
    logic [ANG_W-1:0] n_lat, n_lng, o_lat, o_lng;
    logic [ANG_W-1:0] n_lat_c, n_lng_c, o_lat_c, o_lng_c;

    assign push      = valid_reg && !q_full;
    assign s_ready   = !valid_reg || !q_full;
    assign accept    = s_valid && s_ready;
    assign push_item = item_reg;

    always_comb begin
        n_lat   = s_data.new_packed_normal[PACK_W-1 -: ANG_W];
        n_lng   = s_data.new_packed_normal[ANG_W-1:0];
        o_lat   = s_data.old_packed_normal[PACK_W-1 -: ANG_W];
        o_lng   = s_data.old_packed_normal[ANG_W-1:0];
        n_lat_c = n_lat + ANG_W'(QUARTER_OFS);
        n_lng_c = n_lng + ANG_W'(QUARTER_OFS);
        o_lat_c = o_lat + ANG_W'(QUARTER_OFS);
        o_lng_c = o_lng + ANG_W'(QUARTER_OFS);

        item_next.new_x     = s_data.new_x;
        item_next.new_y     = s_data.new_y;
        item_next.new_z     = s_data.new_z;
        item_next.old_x     = s_data.old_x;
        item_next.old_y     = s_data.old_y;
        item_next.old_z     = s_data.old_z;
        item_next.n_cos_lat = SINE_TAB[n_lat_c];
        item_next.n_sin_lat = SINE_TAB[n_lat];
        item_next.n_sin_lng = SINE_TAB[n_lng];
        item_next.n_cos_lng = SINE_TAB[n_lng_c];
        item_next.o_cos_lat = SINE_TAB[o_lat_c];
        item_next.o_sin_lat = SINE_TAB[o_lat];
        item_next.o_sin_lng = SINE_TAB[o_lng];
        item_next.o_cos_lng = SINE_TAB[o_lng_c];
        item_next.last      = s_data.last_vertex_in;

        if (accept) begin
            valid_next = 1'b1;
        end else if (push) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= item_next;
        end
    end

endmodule

[src/mvl_queue.sv]
module mvl_queue #(
    parameter int DEPTH = mvl_pkg::DEF_QUEUE_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  mvl_pkg::vtx_item_t push_item,
    output logic               full,
    input  logic               pop,
    output logic               empty,
    output mvl_pkg::vtx_item_t head_item
);
    import mvl_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    vtx_item_t        mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = count_reg == CNT_W'(DEPTH);
    assign empty     = count_reg == '0;
    assign head_item = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[src/mvl_back.sv]
module mvl_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [mvl_pkg::WGT_W-1:0]   back_weight,
    input  logic                        q_empty,
    output logic                        q_pop,
    input  mvl_pkg::vtx_item_t          q_item,
    output logic                        m_valid,
    input  logic                        m_ready,
    output mvl_pkg::out_item_t          m_data
);
    import mvl_pkg::*;

    typedef struct packed {
        logic [2:0][POS_W-1:0] pos;
        logic [2:0][NRM_W-1:0] cpy;
        logic                  copy;
        logic                  last;
        logic [2:0][MAG_W-1:0] mag;
        logic [2:0]            neg;
    } side_t;

    logic                   en;
    logic [WGT_W:0]         wn;
    logic signed [WGT_W:0]  w_s;
    logic signed [WGT_W+1:0] wn_s;

    logic      m_valid_reg;
    out_item_t m_data_reg, m_data_next;

    assign en      = !m_valid_reg || m_ready;
    assign q_pop   = en && !q_empty;
    assign wn      = (WGT_W+1)'(WGT_ONE) - {1'b0, back_weight};
    assign w_s     = $signed({1'b0, back_weight});
    assign wn_s    = $signed({1'b0, wn});
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // stage 1: weight products for position, decode products for normals
    logic                      s1_valid_reg;
    logic signed [PP_W-1:0]    s1_po_reg [3], s1_po_next [3];
    logic signed [PP_W-1:0]    s1_pn_reg [3], s1_pn_next [3];
    logic signed [C_W-1:0]     s1_nc_reg [2], s1_nc_next [2];
    logic signed [C_W-1:0]     s1_oc_reg [2], s1_oc_next [2];
    logic signed [SIN_W-1:0]   s1_nz_reg, s1_oz_reg;
    logic                      s1_copy_reg, s1_last_reg;
    logic signed [COORD_W-1:0] new_c [3], old_c [3];

    always_comb begin
        new_c[0] = q_item.new_x;
        new_c[1] = q_item.new_y;
        new_c[2] = q_item.new_z;
        old_c[0] = q_item.old_x;
        old_c[1] = q_item.old_y;
        old_c[2] = q_item.old_z;
        for (int j = 0; j < 3; j++) begin
            s1_po_next[j] = PP_W'(old_c[j]) * PP_W'(w_s);
            s1_pn_next[j] = PP_W'(new_c[j]) * PP_W'(wn_s);
        end
        s1_nc_next[0] = C_W'(q_item.n_cos_lat) * C_W'(q_item.n_sin_lng);
        s1_nc_next[1] = C_W'(q_item.n_sin_lat) * C_W'(q_item.n_sin_lng);
        s1_oc_next[0] = C_W'(q_item.o_cos_lat) * C_W'(q_item.o_sin_lng);
        s1_oc_next[1] = C_W'(q_item.o_sin_lat) * C_W'(q_item.o_sin_lng);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_po_reg   <= s1_po_next;
            s1_pn_reg   <= s1_pn_next;
            s1_nc_reg   <= s1_nc_next;
            s1_oc_reg   <= s1_oc_next;
            s1_nz_reg   <= q_item.n_cos_lng;
            s1_oz_reg   <= q_item.o_cos_lng;
            s1_copy_reg <= back_weight == '0;
            s1_last_reg <= q_item.last;
        end
    end

    // stage 2: position sum, copy-path normals, blend products
    logic                   s2_valid_reg;
    logic signed [PP_W-1:0] pos_sum [3];
    logic signed [C_W:0]    rnd [2];
    logic signed [C_W-1:0]  ncomp [3], ocomp [3];
    logic [2:0][POS_W-1:0]  s2_pos_reg, s2_pos_next;
    logic [2:0][NRM_W-1:0]  s2_cpy_reg, s2_cpy_next;
    logic signed [BL_W-1:0] s2_bo_reg [3], s2_bo_next [3];
    logic signed [BL_W-1:0] s2_bn_reg [3], s2_bn_next [3];
    logic                   s2_copy_reg, s2_last_reg;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            pos_sum[j]     = s1_po_reg[j] + s1_pn_reg[j];
            s2_pos_next[j] = pos_sum[j][POS_SHIFT +: POS_W];
        end
        for (int j = 0; j < 2; j++) begin
            rnd[j]         = (C_W+1)'(s1_nc_reg[j]) + (C_W+1)'(ROUND_Q14);
            s2_cpy_next[j] = rnd[j][FRAC_Q14 +: NRM_W];
        end
        s2_cpy_next[2] = s1_nz_reg;
        ncomp[0] = s1_nc_reg[0];
        ncomp[1] = s1_nc_reg[1];
        ncomp[2] = C_W'(s1_nz_reg) <<< FRAC_Q14;
        ocomp[0] = s1_oc_reg[0];
        ocomp[1] = s1_oc_reg[1];
        ocomp[2] = C_W'(s1_oz_reg) <<< FRAC_Q14;
        for (int j = 0; j < 3; j++) begin
            s2_bo_next[j] = BL_W'(ocomp[j]) * BL_W'(w_s);
            s2_bn_next[j] = BL_W'(ncomp[j]) * BL_W'(wn_s);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_pos_reg  <= s2_pos_next;
            s2_cpy_reg  <= s2_cpy_next;
            s2_bo_reg   <= s2_bo_next;
            s2_bn_reg   <= s2_bn_next;
            s2_copy_reg <= s1_copy_reg;
            s2_last_reg <= s1_last_reg;
        end
    end

    // stage 3: blended components back to Q2.28
    logic                   s3_valid_reg;
    logic signed [BL_W-1:0] bl_sum [3];
    logic signed [C_W-1:0]  s3_c_reg [3], s3_c_next [3];
    logic [2:0][POS_W-1:0]  s3_pos_reg;
    logic [2:0][NRM_W-1:0]  s3_cpy_reg;
    logic                   s3_copy_reg, s3_last_reg;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            bl_sum[j]    = s2_bo_reg[j] + s2_bn_reg[j];
            s3_c_next[j] = bl_sum[j][WGT_SHIFT +: C_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s3_c_reg    <= s3_c_next;
            s3_pos_reg  <= s2_pos_reg;
            s3_cpy_reg  <= s2_cpy_reg;
            s3_copy_reg <= s2_copy_reg;
            s3_last_reg <= s2_last_reg;
        end
    end

    // stage 4: squares and magnitudes
    logic            s4_valid_reg;
    logic [SQ_W-1:0] s4_sq_reg [3], s4_sq_next [3];
    side_t           s4_side_reg, s4_side_next;

    always_comb begin
        s4_side_next.pos  = s3_pos_reg;
        s4_side_next.cpy  = s3_cpy_reg;
        s4_side_next.copy = s3_copy_reg;
        s4_side_next.last = s3_last_reg;
        for (int j = 0; j < 3; j++) begin
            s4_sq_next[j]       = SQ_W'(s3_c_reg[j]) * SQ_W'(s3_c_reg[j]);
            s4_side_next.neg[j] = s3_c_reg[j][C_W-1];
            s4_side_next.mag[j] = s3_c_reg[j][C_W-1] ? MAG_W'(-s3_c_reg[j])
                                                     : MAG_W'(s3_c_reg[j]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s4_sq_reg   <= s4_sq_next;
            s4_side_reg <= s4_side_next;
        end
    end

    // square root: squared length in entry 0, one root bit per stage
    logic [LEN_W-1:0] sr_v_reg [ROOT_W+1], sr_v_next [ROOT_W+1];
    logic [RES_W-1:0] sr_r_reg [ROOT_W+1], sr_r_next [ROOT_W+1];
    logic [RES_W-1:0] sr_bit [ROOT_W], sr_trial [ROOT_W];
    side_t            sr_side_reg [ROOT_W+1];
    logic             sr_valid_reg [ROOT_W+1];

    always_comb begin
        sr_v_next[0] = LEN_W'(s4_sq_reg[0]) + LEN_W'(s4_sq_reg[1]) + LEN_W'(s4_sq_reg[2]);
        sr_r_next[0] = '0;
        for (int k = 0; k < ROOT_W; k++) begin
            sr_bit[k]   = RES_W'(1) << (2 * (ROOT_W - 1 - k));
            sr_trial[k] = sr_r_reg[k] + sr_bit[k];
            if (RES_W'(sr_v_reg[k]) >= sr_trial[k]) begin
                sr_v_next[k+1] = sr_v_reg[k] - sr_trial[k][LEN_W-1:0];
                sr_r_next[k+1] = (sr_r_reg[k] >> 1) + sr_bit[k];
            end else begin
                sr_v_next[k+1] = sr_v_reg[k];
                sr_r_next[k+1] = sr_r_reg[k] >> 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sr_side_reg[0] <= s4_side_reg;
            for (int k = 0; k <= ROOT_W; k++) begin
                sr_v_reg[k] <= sr_v_next[k];
                sr_r_reg[k] <= sr_r_next[k];
            end
            for (int k = 0; k < ROOT_W; k++) begin
                sr_side_reg[k+1] <= sr_side_reg[k];
            end
        end
    end

    // restoring division, one quotient bit per stage, three lanes
    logic [ROOT_W-1:0] root;
    logic [QN_W-1:0]   dv_rem_reg [Q_W+1][3], dv_rem_next [Q_W+1][3];
    logic [Q_W-1:0]    dv_q_reg [Q_W+1][3], dv_q_next [Q_W+1][3];
    logic [QN_W-1:0]   dv_dsh [Q_W];
    logic [ROOT_W-1:0] dv_d_reg [Q_W+1];
    side_t             dv_side_reg [Q_W+1];
    logic              dv_valid_reg [Q_W+1];

    assign root = sr_r_reg[ROOT_W][ROOT_W-1:0];

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            dv_rem_next[0][j] = (QN_W'(sr_side_reg[ROOT_W].mag[j]) << FRAC_Q14)
                              + QN_W'(root >> 1);
            dv_q_next[0][j]   = '0;
        end
        for (int k = 0; k < Q_W; k++) begin
            dv_dsh[k] = QN_W'(dv_d_reg[k]) << (Q_W - 1 - k);
            for (int j = 0; j < 3; j++) begin
                if (dv_rem_reg[k][j] >= dv_dsh[k]) begin
                    dv_rem_next[k+1][j] = dv_rem_reg[k][j] - dv_dsh[k];
                    dv_q_next[k+1][j]   = dv_q_reg[k][j] | (Q_W'(1) << (Q_W - 1 - k));
                end else begin
                    dv_rem_next[k+1][j] = dv_rem_reg[k][j];
                    dv_q_next[k+1][j]   = dv_q_reg[k][j];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dv_d_reg[0]    <= root;
            dv_side_reg[0] <= sr_side_reg[ROOT_W];
            for (int k = 0; k <= Q_W; k++) begin
                dv_rem_reg[k] <= dv_rem_next[k];
                dv_q_reg[k]   <= dv_q_next[k];
            end
            for (int k = 0; k < Q_W; k++) begin
                dv_d_reg[k+1]    <= dv_d_reg[k];
                dv_side_reg[k+1] <= dv_side_reg[k];
            end
        end
    end

    // output register
    logic [Q_W-1:0]          q_sat [3];
    logic signed [NRM_W-1:0] nrm [3];
    side_t                   fin;

    always_comb begin
        fin = dv_side_reg[Q_W];
        for (int j = 0; j < 3; j++) begin
            q_sat[j] = (dv_q_reg[Q_W][j] > Q_W'(NORM_ONE)) ? Q_W'(NORM_ONE)
                                                             : dv_q_reg[Q_W][j];
            if (fin.copy) begin
                nrm[j] = fin.cpy[j];
            end else if (dv_d_reg[Q_W] == '0) begin
                nrm[j] = '0;
            end else if (fin.neg[j]) begin
                nrm[j] = -NRM_W'(q_sat[j]);
            end else begin
                nrm[j] = NRM_W'(q_sat[j]);
            end
        end
        m_data_next.pos_x           = fin.pos[0];
        m_data_next.pos_y           = fin.pos[1];
        m_data_next.pos_z           = fin.pos[2];
        m_data_next.norm_x          = nrm[0];
        m_data_next.norm_y          = nrm[1];
        m_data_next.norm_z          = nrm[2];
        m_data_next.last_vertex_out = fin.last;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= m_data_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            for (int k = 0; k <= ROOT_W; k++) begin
                sr_valid_reg[k] <= 1'b0;
            end
            for (int k = 0; k <= Q_W; k++) begin
                dv_valid_reg[k] <= 1'b0;
            end
            m_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg    <= q_pop;
            s2_valid_reg    <= s1_valid_reg;
            s3_valid_reg    <= s2_valid_reg;
            s4_valid_reg    <= s3_valid_reg;
            sr_valid_reg[0] <= s4_valid_reg;
            for (int k = 0; k < ROOT_W; k++) begin
                sr_valid_reg[k+1] <= sr_valid_reg[k];
            end
            dv_valid_reg[0] <= sr_valid_reg[ROOT_W];
            for (int k = 0; k < Q_W; k++) begin
                dv_valid_reg[k+1] <= dv_valid_reg[k];
            end
            m_valid_reg <= dv_valid_reg[Q_W];
        end
    end

endmodule

[src/morph_vertex_lerp.sv]
// Throughput: one vertex per cycle when the output is not stalled; the back pipeline
// (square root and divider, one bit per stage) advances as a whole whenever its
// output register is free.
// Reset: synchronous active-low aresetn clears all valid flags, the queue pointers
// and back_weight (to zero); the sine table is constant logic.
module morph_vertex_lerp #(
    parameter int QUEUE_DEPTH = mvl_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [mvl_pkg::WGT_W-1:0] cfg_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  mvl_pkg::in_item_t         s_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output mvl_pkg::out_item_t        m_data
);
    import mvl_pkg::*;

    logic [WGT_W-1:0] back_weight_reg;
    logic             push;
    logic             q_full;
    logic             q_empty;
    logic             q_pop;
    vtx_item_t        push_item;
    vtx_item_t        head_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            back_weight_reg <= '0;
        end else if (cfg_valid) begin
            back_weight_reg <= cfg_data;
        end
    end

    mvl_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .push      (push),
        .push_item (push_item),
        .q_full    (q_full)
    );

    mvl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head_item (head_item)
    );

    mvl_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .back_weight (back_weight_reg),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .q_item      (head_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

[tb/sv/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mvl_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 70;
    localparam int PHASE_ITEMS = 105;
    localparam longint unsigned QUARTER_PI_RAD_Q62 = 64'd7244019458077122842;

    typedef struct {
        logic [WGT_W-1:0] wgt;
        in_item_t         stim;
        bit               typed;
        out_item_t        want;
    } vec_row_t;

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [WGT_W-1:0] cfg_data;
    logic       s_valid;
    logic       s_ready;
    in_item_t   s_data;
    logic       m_valid;
    logic       m_ready;
    out_item_t  m_data;

    longint     sine_q14 [SINE_ENTRIES];
    int unsigned cur_weight;
    out_item_t  pending_vertices [$];
    int         mismatches;
    int         checked;
    int         weight_writes;
    int         cycles;
    bit         quiet_tail;
    bit         long_hold_req;
    int         hold_left;
    vec_row_t   rows [$];

    always #6 aclk = ~aclk;

    morph_vertex_lerp i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    function automatic longint unsigned q62_mul(longint unsigned a, longint unsigned b);
        logic [127:0] p;
        p = 128'(a) * 128'(b);
        return p[125:62];
    endfunction

    function automatic longint unsigned quarter_sine(longint unsigned num, longint unsigned den);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned acc;
        x = (QUARTER_PI_RAD_Q62 / den) * num + ((QUARTER_PI_RAD_Q62 % den) * num) / den;
        x2 = q62_mul(x, x);
        term = x;
        acc = x;
        for (int k = 1; k <= 14; k++) begin
            term = q62_mul(term, x2) / longint'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) begin
                acc = acc - term;
            end else begin
                acc = acc + term;
            end
        end
        return acc;
    endfunction

    function automatic void fill_sine_q14();
        longint unsigned den;
        longint unsigned n;
        longint unsigned quad;
        longint unsigned r;
        longint unsigned s;
        longint e;
        den = SINE_ENTRIES - 1;
        for (int i = 0; i < SINE_ENTRIES; i++) begin
            n = 4 * i;
            quad = (n / den) & 3;
            r = n % den;
            s = quad[0] ? quarter_sine(den - r, den) : quarter_sine(r, den);
            e = longint'((s + (64'd1 << 47)) >> 48);
            sine_q14[i] = quad[1] ? -e : e;
        end
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned b;
        root = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= root + b) begin
                v = v - (root + b);
                root = (root >> 1) + b;
            end else begin
                root = root >> 1;
            end
            b = b >> 2;
        end
        return root;
    endfunction

    function automatic void unpack_normal(logic [PACK_W-1:0] p, output longint c [3]);
        int lat;
        int lng;
        lat = int'(p[15:8]) * 4;
        lng = int'(p[7:0]) * 4;
        c[0] = sine_q14[(lat + 256) % 1024] * sine_q14[lng];
        c[1] = sine_q14[lat] * sine_q14[lng];
        c[2] = sine_q14[(lng + 256) % 1024] * 16384;
    endfunction

    function automatic out_item_t lerp_vertex(in_item_t it, int unsigned wgt);
        out_item_t o;
        longint w;
        longint wn;
        longint nc [3];
        longint oc [3];
        longint nn [3];
        longint on [3];
        longint res [3];
        longint unsigned len2;
        longint unsigned root;
        longint unsigned mag;
        longint unsigned q;
        w = longint'(wgt);
        wn = 65536 - w;
        nc = '{longint'(it.new_x), longint'(it.new_y), longint'(it.new_z)};
        oc = '{longint'(it.old_x), longint'(it.old_y), longint'(it.old_z)};
        o.pos_x = POS_W'((oc[0] * w + nc[0] * wn) >>> 8);
        o.pos_y = POS_W'((oc[1] * w + nc[1] * wn) >>> 8);
        o.pos_z = POS_W'((oc[2] * w + nc[2] * wn) >>> 8);
        unpack_normal(it.new_packed_normal, nn);
        if (w == 0) begin
            res[0] = (nn[0] + 8192) >>> 14;
            res[1] = (nn[1] + 8192) >>> 14;
            res[2] = nn[2] / 16384;
        end else begin
            unpack_normal(it.old_packed_normal, on);
            len2 = 0;
            for (int j = 0; j < 3; j++) begin
                nn[j] = (on[j] * w + nn[j] * wn) >>> 16;
                len2 += unsigned'(nn[j] * nn[j]);
            end
            root = int_sqrt(len2);
            for (int j = 0; j < 3; j++) begin
                if (root == 0) begin
                    res[j] = 0;
                end else begin
                    mag = unsigned'(nn[j] < 0 ? -nn[j] : nn[j]);
                    q = (mag * 16384 + root / 2) / root;
                    if (q > 16384) q = 16384;
                    res[j] = nn[j] < 0 ? -longint'(q) : longint'(q);
                end
            end
        end
        o.norm_x = NRM_W'(res[0]);
        o.norm_y = NRM_W'(res[1]);
        o.norm_z = NRM_W'(res[2]);
        o.last_vertex_out = it.last_vertex_in;
        return o;
    endfunction

    function automatic in_item_t vtx(int nx, int ny, int nz, int np,
                                     int ox, int oy, int oz, int op, int lst);
        in_item_t it;
        it.new_x = COORD_W'(nx);
        it.new_y = COORD_W'(ny);
        it.new_z = COORD_W'(nz);
        it.new_packed_normal = PACK_W'(np);
        it.old_x = COORD_W'(ox);
        it.old_y = COORD_W'(oy);
        it.old_z = COORD_W'(oz);
        it.old_packed_normal = PACK_W'(op);
        it.last_vertex_in = lst[0];
        return it;
    endfunction

    function automatic out_item_t vres(int px, int py, int pz, int rx, int ry, int rz, int lst);
        out_item_t o;
        o.pos_x = POS_W'(px);
        o.pos_y = POS_W'(py);
        o.pos_z = POS_W'(pz);
        o.norm_x = NRM_W'(rx);
        o.norm_y = NRM_W'(ry);
        o.norm_z = NRM_W'(rz);
        o.last_vertex_out = lst[0];
        return o;
    endfunction

    function automatic void add_row(int wgt, in_item_t it, bit typed, out_item_t want);
        vec_row_t r;
        r.wgt = WGT_W'(wgt);
        r.stim = it;
        r.typed = typed;
        r.want = want;
        rows.push_back(r);
    endfunction

    function automatic logic [COORD_W-1:0] rand_coord();
        case ($urandom_range(0, 11))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'sh0000;
            3: return 16'shffff;
            default: return COORD_W'($urandom);
        endcase
    endfunction

    function automatic in_item_t rand_vertex();
        in_item_t it;
        it.new_x = rand_coord();
        it.new_y = rand_coord();
        it.new_z = rand_coord();
        it.new_packed_normal = PACK_W'($urandom);
        it.old_x = rand_coord();
        it.old_y = rand_coord();
        it.old_z = rand_coord();
        it.old_packed_normal = PACK_W'($urandom);
        it.last_vertex_in = 1'($urandom_range(0, 1));
        return it;
    endfunction

    task automatic drain_results();
        while (pending_vertices.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_weight(logic [WGT_W-1:0] wgt);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data <= wgt;
        do @(posedge aclk); while (!cfg_ready);
        cur_weight = 32'(wgt);
        weight_writes++;
        cfg_valid <= 1'b0;
    endtask

    task automatic send_vertex(in_item_t it, bit typed, out_item_t want);
        s_valid <= 1'b1;
        s_data <= it;
        do @(posedge aclk); while (!s_ready);
        pending_vertices.push_back(typed ? want : lerp_vertex(it, cur_weight));
        if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
    endtask

    function automatic void check_vertex(out_item_t got);
        out_item_t exp_v;
        if (pending_vertices.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            mismatches++;
            return;
        end
        exp_v = pending_vertices.pop_front();
        checked++;
        if (got.pos_x !== exp_v.pos_x) begin
            $display("%0t: pos_x exp %0d got %0d", $time, exp_v.pos_x, got.pos_x);
            mismatches++;
        end
        if (got.pos_y !== exp_v.pos_y) begin
            $display("%0t: pos_y exp %0d got %0d", $time, exp_v.pos_y, got.pos_y);
            mismatches++;
        end
        if (got.pos_z !== exp_v.pos_z) begin
            $display("%0t: pos_z exp %0d got %0d", $time, exp_v.pos_z, got.pos_z);
            mismatches++;
        end
        if (got.norm_x !== exp_v.norm_x) begin
            $display("%0t: norm_x exp %0d got %0d", $time, exp_v.norm_x, got.norm_x);
            mismatches++;
        end
        if (got.norm_y !== exp_v.norm_y) begin
            $display("%0t: norm_y exp %0d got %0d", $time, exp_v.norm_y, got.norm_y);
            mismatches++;
        end
        if (got.norm_z !== exp_v.norm_z) begin
            $display("%0t: norm_z exp %0d got %0d", $time, exp_v.norm_z, got.norm_z);
            mismatches++;
        end
        if (got.last_vertex_out !== exp_v.last_vertex_out) begin
            $display("%0t: last exp %0b got %0b", $time, exp_v.last_vertex_out,
                     got.last_vertex_out);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        m_ready <= 1'b0;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) check_vertex(m_data);
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= (hold_left == 0);
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left = 400;
                m_ready <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
                hold_left = $urandom_range(1, 11);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        logic [WGT_W-1:0] phase_wgt [8];
        out_item_t none;
        cycles = 0;
        mismatches = 0;
        checked = 0;
        weight_writes = 0;
        quiet_tail = 1'b0;
        long_hold_req = 1'b0;
        none = '0;
        aresetn <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data <= '0;
        s_valid <= 1'b0;
        s_data <= '0;
        fill_sine_q14();
        cur_weight = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        add_row(0, vtx(32767, -32768, 0, 0, 0, 0, 0, 0, 1), 1,
                vres(8388352, -8388608, 0, 0, 0, 16384, 1));
        add_row(0, vtx(-1, 1, -32768, 0, -32768, 32767, -1, 16'hffff, 0), 1,
                vres(-256, 256, -8388608, 0, 0, 16384, 0));
        add_row(0, vtx(100, -200, 300, 16'hffff, 5, 6, 7, 0, 1), 0, none);
        add_row(0, vtx(0, 0, 0, 16'h40c0, 0, 0, 0, 0, 0), 0, none);
        add_row(0, vtx(1, 2, 3, 16'h8000, 0, 0, 0, 0, 0), 0, none);
        add_row(0, vtx(-5, 7, 9, 16'h00ff, 0, 0, 0, 0, 1), 0, none);
        add_row(0, vtx(1234, -4321, 77, 16'h7f3a, 0, 0, 0, 0, 0), 0, none);
        add_row(65535, vtx(32767, 32767, -32768, 0, -32768, -32768, 32767, 16'h0080, 1), 0, none);
        add_row(65535, vtx(-32768, 0, 32767, 16'hffff, 32767, -1, -32768, 16'h0000, 0), 0, none);
        add_row(65535, vtx(1, -1, 0, 16'h8040, -1, 1, 0, 16'h40c0, 0), 0, none);
        add_row(32768, vtx(32767, -32768, 10, 16'h0000, -32768, 32767, -10, 16'h0080, 1), 0, none);
        add_row(32768, vtx(0, 0, 0, 16'h0040, 0, 0, 0, 16'h00c0, 0), 0, none);
        add_row(32768, vtx(-3, 3, -3, 16'h4000, 3, -3, 3, 16'hc000, 0), 0, none);
        add_row(1, vtx(32767, -32768, 32767, 16'h1234, -32768, 32767, -32768, 16'hfedc, 1), 0,
                none);
        add_row(1, vtx(-1, -1, -1, 16'h0080, 0, 0, 0, 16'h0000, 0), 0, none);

        foreach (rows[i]) begin
            if (rows[i].wgt != cur_weight || (i == 0)) begin
                s_valid <= 1'b0;
                write_weight(rows[i].wgt);
            end
            send_vertex(rows[i].stim, rows[i].typed, rows[i].want);
        end

        phase_wgt[0] = 16'h0000;
        phase_wgt[1] = WGT_W'($urandom);
        phase_wgt[2] = 16'hffff;
        phase_wgt[3] = WGT_W'($urandom);
        phase_wgt[4] = 16'h0001;
        phase_wgt[5] = ~phase_wgt[3];
        phase_wgt[6] = 16'h8000;
        phase_wgt[7] = WGT_W'($urandom);
        for (int p = 0; p < 8; p++) begin
            s_valid <= 1'b0;
            write_weight(phase_wgt[p]);
            if (p == 7) quiet_tail = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 3 && n == 10) long_hold_req = 1'b1;
                send_vertex(rand_vertex(), 0, none);
            end
        end
        s_valid <= 1'b0;

        drain_results();
        if (pending_vertices.size() != 0) mismatches++;
        $display("Checked %0d vertices across %0d back-weight settings,", checked, weight_writes);
        $display("copy and blend paths, with stalls on both sides and one long output hold.");
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
